FILE: rtl/core/csnp_pkg.sv
// Shared types and constants for the circle snap block.
package csnp_pkg;

  localparam int MAX_ENTITIES_DEF = 256;
  localparam int INDEX_SPAN = 256;             // slots reachable by an 8-bit index
  localparam logic [30:0] SNAP_RESET = 31'd327680;
  localparam int SQRT_STEPS = 33;              // two radicand bits per step, 66-bit d2
  localparam int DIV_STEPS = 32;               // quotient bits
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_PICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_SNAP_DIST = 1'b0,
    REG_ENT_COUNT = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ENT_WRITE,
    OP_HL_READ,
    OP_SCAN_INIT,
    OP_ENT_READ,
    OP_SCAN_NEXT,
    OP_DIFF,
    OP_MUL_DX,
    OP_MUL_DY,
    OP_MUL_RS,
    OP_MUL_RD,
    OP_TEST,
    OP_SQRT_STEP,
    OP_MUL_NX,
    OP_MUL_NY,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FIN_X,
    OP_FIN_Y
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_CHK,
    S_MDX,
    S_MDY,
    S_MRS,
    S_MRD,
    S_TEST,
    S_SQRT,
    S_MNX,
    S_DIXX,
    S_DIVX,
    S_FINX,
    S_MNY,
    S_DIXY,
    S_DIVY,
    S_FINY,
    S_RESP
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_done;
    logic       is_circle;
    logic       test_hit;
  } dp_stat_t;

endpackage

FILE: rtl/core/circle_snap_nearest_point.sv
// Top level of the circle snap block: controller and datapath.
//
// Input channel (in_valid_i/in_ready_o) carries one command beat: write an
// entity slot, run a pick query, or read a slot's highlight mark. Every beat
// yields exactly one result beat on the output channel (out_valid_o/out_ready_i).
// The config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 is the
// snap distance, index 1 the entity count. Write config only while idle.
// On a hit, a 33-step square root and two 32-step divides, one bit per cycle,
// set the cost of a pick; the scan over the entity RAM read port sets the rest.
// One command is in flight at a time; in_ready_o is high only while idle.
// The result register holds a finished beat while the receiver stalls; the
// next command is taken meanwhile and waits at its end for the slot to free.
// Reset clears the highlight marks, the last snap point and selection, and
// the config registers to their defaults. Entity slots are undefined until
// written.
module circle_snap_nearest_point #(
  parameter int MAX_ENTITIES = csnp_pkg::MAX_ENTITIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         index_i,
  input  logic               is_circle_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [30:0]        radius_i,
  input  logic signed [31:0] mouse_x_i,
  input  logic signed [31:0] mouse_y_i,
  input  logic signed [31:0] mouse_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [7:0]         selected_index_o,
  output logic signed [31:0] snap_x_o,
  output logic signed [31:0] snap_y_o,
  output logic signed [31:0] snap_z_o,
  output logic               highlight_o
);
  import csnp_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  csnp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  csnp_dp #(.MAX_ENTITIES(MAX_ENTITIES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_in_i        (cmd_i),
    .index_i         (index_i),
    .is_circle_i     (is_circle_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .radius_i        (radius_i),
    .mouse_x_i       (mouse_x_i),
    .mouse_y_i       (mouse_y_i),
    .mouse_z_i       (mouse_z_i),
    .hit_o           (hit_o),
    .selected_index_o(selected_index_o),
    .snap_x_o        (snap_x_o),
    .snap_y_o        (snap_y_o),
    .snap_z_o        (snap_z_o),
    .highlight_o     (highlight_o)
  );

endmodule

FILE: rtl/core/csnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/csnp_ctrl.sv
// Sequencer for writes, reads and pick scans of the circle snap block.
module csnp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  csnp_pkg::dp_stat_t  stat_i,
  output csnp_pkg::dp_cmd_t   cmd_o
);
  import csnp_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          CMD_WRITE: begin
            cmd_o.op = OP_ENT_WRITE;
            state_d  = S_RESP;
          end
          CMD_READ: begin
            cmd_o.op = OP_HL_READ;
            state_d  = S_RESP;
          end
          CMD_PICK: begin
            cmd_o.op = OP_SCAN_INIT;
            state_d  = S_SCAN;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_RESP;
        end else begin
          cmd_o.op = OP_ENT_READ;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.is_circle) begin
          cmd_o.op = OP_DIFF;
          state_d  = S_MDX;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_SCAN;
        end
      end
      S_MDX: begin
        cmd_o.op = OP_MUL_DX;
        state_d  = S_MDY;
      end
      S_MDY: begin
        cmd_o.op = OP_MUL_DY;
        state_d  = S_MRS;
      end
      S_MRS: begin
        cmd_o.op = OP_MUL_RS;
        state_d  = S_MRD;
      end
      S_MRD: begin
        cmd_o.op = OP_MUL_RD;
        state_d  = S_TEST;
      end
      S_TEST: begin
        // miss advances the scan inside the datapath
        cmd_o.op = OP_TEST;
        cnt_d    = '0;
        state_d  = stat_i.test_hit ? S_SQRT : S_SCAN;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = S_MNX;
        end
      end
      S_MNX: begin
        cmd_o.op = OP_MUL_NX;
        state_d  = S_DIXX;
      end
      S_DIXX: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FINX;
        end
      end
      S_FINX: begin
        cmd_o.op = OP_FIN_X;
        state_d  = S_MNY;
      end
      S_MNY: begin
        cmd_o.op = OP_MUL_NY;
        state_d  = S_DIXY;
      end
      S_DIXY: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FINY;
        end
      end
      S_FINY: begin
        cmd_o.op = OP_FIN_Y;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted beat did not start work");

  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (cnt_q < CNT_W'(SQRT_STEPS)))
    else $error("sqrt step count out of range");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVY) |-> (cnt_q < CNT_W'(DIV_STEPS)))
    else $error("divide step count out of range");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

FILE: rtl/core/csnp_dp.sv
// Datapath: entity tables, shared multiplier, square root and divider, result register.
module csnp_dp #(
  parameter int MAX_ENTITIES = csnp_pkg::MAX_ENTITIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csnp_pkg::dp_cmd_t  cmd_i,
  output csnp_pkg::dp_stat_t stat_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [1:0]         cmd_in_i,
  input  logic [7:0]         index_i,
  input  logic               is_circle_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [30:0]        radius_i,
  input  logic signed [31:0] mouse_x_i,
  input  logic signed [31:0] mouse_y_i,
  input  logic signed [31:0] mouse_z_i,
  output logic               hit_o,
  output logic [7:0]         selected_index_o,
  output logic signed [31:0] snap_x_o,
  output logic signed [31:0] snap_y_o,
  output logic signed [31:0] snap_z_o,
  output logic               highlight_o
);
  import csnp_pkg::*;

  localparam int DEPTH = (MAX_ENTITIES < INDEX_SPAN) ? MAX_ENTITIES : INDEX_SPAN;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = 1 + 32 + 32 + 31;

  // configuration
  logic [30:0] snap_q;
  logic [8:0]  count_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q  <= SNAP_RESET;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_SNAP_DIST: snap_q  <= cfg_data_i[30:0];
        REG_ENT_COUNT: count_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic [1:0]         cmd_q;
  logic [7:0]         idx_q;
  logic               flag_w_q;
  logic signed [31:0] cx_w_q, cy_w_q, mx_q, my_q, mz_q;
  logic [30:0]        r_w_q;
  logic               idx_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CAPTURE) begin
      cmd_q    <= cmd_in_i;
      idx_q    <= index_i;
      flag_w_q <= is_circle_i;
      cx_w_q   <= center_x_i;
      cy_w_q   <= center_y_i;
      r_w_q    <= radius_i;
      mx_q     <= mouse_x_i;
      my_q     <= mouse_y_i;
      mz_q     <= mouse_z_i;
    end
  end

  assign idx_ok = (32'(idx_q) < MAX_ENTITIES);

  // scan counter
  logic [8:0] scan_q;
  logic [8:0] scan_n;
  logic       test_hit;

  assign scan_n = (count_q < 9'(DEPTH)) ? count_q : 9'(DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.op == OP_SCAN_INIT) begin
      scan_q <= '0;
    end else if (cmd_i.op == OP_SCAN_NEXT || (cmd_i.op == OP_TEST && !test_hit)) begin
      scan_q <= scan_q + 1'b1;
    end
  end

  // entity table
  logic [EW-1:0]      ent_rd;
  logic               e_flag;
  logic signed [31:0] e_cx, e_cy;
  logic [30:0]        e_r;

  csnp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.op == OP_ENT_WRITE && idx_ok),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i({flag_w_q, cx_w_q, cy_w_q, r_w_q}),
    .re_i   (cmd_i.op == OP_ENT_READ),
    .raddr_i(scan_q[AW-1:0]),
    .rdata_o(ent_rd)
  );

  assign {e_flag, e_cx, e_cy, e_r} = ent_rd;

  // highlight table, valid bit per slot gives the all-zero reset
  logic             hl_rd;
  logic             hl_we;
  logic [DEPTH-1:0] hl_vld_q;
  logic             hl_vld_rd_q;

  assign hl_we = (cmd_i.op == OP_TEST);

  csnp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_hl_ram (
    .clk_i  (clk_i),
    .we_i   (hl_we),
    .waddr_i(scan_q[AW-1:0]),
    .wdata_i(test_hit),
    .re_i   (cmd_i.op == OP_HL_READ),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(hl_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_vld_q    <= '0;
      hl_vld_rd_q <= 1'b0;
    end else begin
      if (hl_we) begin
        hl_vld_q[scan_q[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.op == OP_HL_READ) begin
        hl_vld_rd_q <= hl_vld_q[idx_q[AW-1:0]];
      end
    end
  end

  // differences and radius sum / difference
  logic signed [32:0] dx_q, dy_q;
  logic [31:0]        rs_q;
  logic [30:0]        rd_q;
  logic [30:0]        r_q;
  logic signed [31:0] cx_q, cy_q;
  logic [32:0]        adx, ady;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIFF) begin
      dx_q <= 33'(mx_q) - 33'(e_cx);
      dy_q <= 33'(my_q) - 33'(e_cy);
      rs_q <= 32'(snap_q) + 32'(e_r);
      rd_q <= (snap_q > e_r) ? snap_q - e_r : e_r - snap_q;
      r_q  <= e_r;
      cx_q <= e_cx;
      cy_q <= e_cy;
    end
  end

  assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

  // shared multiplier, one product per cycle
  logic [32:0] mul_a, mul_b;
  logic [65:0] p_q, d2_q, rs2_q;

  always_comb begin
    mul_a = adx;
    mul_b = adx;
    case (cmd_i.op)
      OP_MUL_DY: begin
        mul_a = ady;
        mul_b = ady;
      end
      OP_MUL_RS: begin
        mul_a = 33'(rs_q);
        mul_b = 33'(rs_q);
      end
      OP_MUL_RD: begin
        mul_a = 33'(rd_q);
        mul_b = 33'(rd_q);
      end
      OP_MUL_NX: begin
        mul_a = 33'(r_q);
        mul_b = adx;
      end
      OP_MUL_NY: begin
        mul_a = 33'(r_q);
        mul_b = ady;
      end
      default: ;
    endcase
  end

  // products are registered in p_q in turn: dx^2, dy^2, rs^2, rd^2
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MUL_DX, OP_MUL_NX, OP_MUL_NY: p_q <= mul_a * mul_b;
      OP_MUL_DY: begin
        p_q  <= mul_a * mul_b;
        d2_q <= p_q;
      end
      OP_MUL_RS: begin
        p_q  <= mul_a * mul_b;
        d2_q <= d2_q + p_q;
      end
      OP_MUL_RD: begin
        p_q   <= mul_a * mul_b;
        rs2_q <= p_q;
      end
      default: ;
    endcase
  end

  // p_q holds rd^2 during the test
  assign test_hit = (d2_q <= rs2_q) && (d2_q >= p_q) && (d2_q != '0);

  // integer square root, two radicand bits per step
  logic [65:0] rad_q;
  logic [34:0] rem_q;
  logic [32:0] root_q;
  logic [36:0] rem_sh, trial;
  logic        sq_ge;

  assign rem_sh = {rem_q, rad_q[65:64]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_TEST) begin
      rad_q  <= d2_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.op == OP_SQRT_STEP) begin
      rad_q  <= {rad_q[63:0], 2'b00};
      rem_q  <= sq_ge ? 35'(rem_sh - trial) : rem_sh[34:0];
      root_q <= {root_q[31:0], sq_ge};
    end
  end

  // restoring divide of r*|delta| by root; quotient fits 32 bits
  logic [32:0] drem_q;
  logic [31:0] num_q, quo_q;
  logic [33:0] dsh;
  logic        dv_ge;
  logic        rnd_up;
  logic [32:0] q_rnd;
  logic        neg;
  logic signed [31:0] cen;
  logic signed [33:0] off, sum;
  logic signed [31:0] sat;
  logic signed [31:0] sx_q;

  assign dsh   = {drem_q, num_q[31]};
  assign dv_ge = (dsh >= {1'b0, root_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_INIT) begin
      drem_q <= {1'b0, p_q[63:32]};
      num_q  <= p_q[31:0];
      quo_q  <= '0;
    end else if (cmd_i.op == OP_DIV_STEP) begin
      drem_q <= dv_ge ? 33'(dsh - {1'b0, root_q}) : dsh[32:0];
      num_q  <= {num_q[30:0], 1'b0};
      quo_q  <= {quo_q[30:0], dv_ge};
    end
  end

  assign rnd_up = ({drem_q, 1'b0} >= {1'b0, root_q});
  assign q_rnd  = {1'b0, quo_q} + 33'(rnd_up);
  assign neg    = (cmd_i.op == OP_FIN_Y) ? dy_q[32] : dx_q[32];
  assign cen    = (cmd_i.op == OP_FIN_Y) ? cy_q : cx_q;
  assign off    = neg ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
  assign sum    = 34'(cen) + off;

  always_comb begin
    if (sum > 34'sd2147483647) begin
      sat = 32'sh7FFFFFFF;
    end else if (sum < -34'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  // last snap state
  logic signed [31:0] last_x_q, last_y_q, last_z_q;
  logic [7:0]         last_sel_q;
  logic               pick_hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN_X) begin
      sx_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q   <= '0;
      last_y_q   <= '0;
      last_z_q   <= '0;
      last_sel_q <= '0;
      pick_hit_q <= 1'b0;
    end else if (cmd_i.op == OP_CAPTURE) begin
      pick_hit_q <= 1'b0;
    end else if (cmd_i.op == OP_FIN_Y) begin
      last_x_q   <= sx_q;
      last_y_q   <= sat;
      last_z_q   <= mz_q;
      last_sel_q <= scan_q[7:0];
      pick_hit_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hit_o            <= pick_hit_q;
      selected_index_o <= last_sel_q;
      snap_x_o         <= last_x_q;
      snap_y_o         <= last_y_q;
      snap_z_o         <= last_z_q;
      highlight_o      <= (cmd_q == CMD_READ) && idx_ok && hl_vld_rd_q && hl_rd;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.scan_done = (scan_q >= scan_n);
  assign stat_o.is_circle = e_flag;
  assign stat_o.test_hit  = test_hit;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the circle snap block: random and directed commands.
`timescale 1ns / 100ps

module testbench;
  import csnp_pkg::*;

  localparam int SLOTS = 256;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  index;
    logic        is_circle;
    logic [31:0] cx, cy;
    logic [30:0] r;
    logic [31:0] mx, my, mz;
  } cmd_item_t;

  typedef struct {
    logic        hit;
    logic [7:0]  sel;
    logic [31:0] sx, sy, sz;
    logic        hl;
  } snap_result_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] cmd_i;
  logic [7:0] index_i;
  logic is_circle_i;
  logic signed [31:0] center_x_i, center_y_i, mouse_x_i, mouse_y_i, mouse_z_i;
  logic [30:0] radius_i;
  logic out_valid_o, out_ready_i, hit_o, highlight_o;
  logic [7:0] selected_index_o;
  logic signed [31:0] snap_x_o, snap_y_o, snap_z_o;

  circle_snap_nearest_point uut (.*);

  // predictor state
  logic [30:0] p_snap;
  logic [8:0]  ent_count;
  logic        p_circle [SLOTS];
  logic [31:0] p_cx [SLOTS], p_cy [SLOTS];
  logic [30:0] p_r [SLOTS];
  logic        p_hl [SLOTS];
  logic [31:0] last_x, last_y, last_z;
  logic [7:0]  last_sel;

  // shadow of the table at generation time, for building hits
  logic [31:0] g_cx [SLOTS], g_cy [SLOTS];
  logic [30:0] g_r [SLOTS];
  logic [30:0] g_snap;
  int          g_count;

  cmd_item_t    pend_cmds[$];
  snap_result_t expected_results[$];
  int errors = 0;
  int accepted = 0;
  longint cycles = 0;

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] snap_coord(longint c, longint delta,
                                             logic [30:0] r, logic [71:0] d);
    logic [71:0] num, q, rem;
    longint off, s;
    num = 72'(r) * 72'(mag64(delta));
    q = num / d;
    rem = num % d;
    if (2 * rem >= d) q = q + 1;
    off = longint'(q);
    if (delta < 0) off = -off;
    s = c + off;
    if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
    if (s < -64'sh80000000) s = -64'sh80000000;
    return s[31:0];
  endfunction

  function automatic snap_result_t predict_snap(cmd_item_t it);
    snap_result_t res;
    int n;
    longint dx, dy, cxl, cyl, rs, rd;
    logic [71:0] d2, cand, root;
    res.hit = 0;
    res.hl = 0;
    case (it.cmd)
      CMD_WRITE: begin
        p_circle[it.index] = it.is_circle;
        p_cx[it.index] = it.cx;
        p_cy[it.index] = it.cy;
        p_r[it.index] = it.r;
      end
      CMD_PICK: begin
        n = ent_count > SLOTS ? SLOTS : ent_count;
        for (int i = 0; i < n; i++) begin
          if (!p_circle[i]) continue;
          cxl = longint'(signed'(p_cx[i]));
          cyl = longint'(signed'(p_cy[i]));
          dx = longint'(signed'(it.mx)) - cxl;
          dy = longint'(signed'(it.my)) - cyl;
          d2 = 72'(mag64(dx)) * 72'(mag64(dx)) + 72'(mag64(dy)) * 72'(mag64(dy));
          rs = longint'(p_snap) + longint'(p_r[i]);
          rd = mag64(longint'(p_snap) - longint'(p_r[i]));
          if (d2 > 72'(rs) * 72'(rs) || d2 < 72'(rd) * 72'(rd) || d2 == 0) begin
            p_hl[i] = 0;
            continue;
          end
          root = 0;
          for (int b = 33; b >= 0; b--) begin
            cand = root | (72'd1 << b);
            if (cand * cand <= d2) root = cand;
          end
          p_hl[i] = 1;
          last_sel = i[7:0];
          last_x = snap_coord(cxl, dx, p_r[i], root);
          last_y = snap_coord(cyl, dy, p_r[i], root);
          last_z = it.mz;
          res.hit = 1;
          break;
        end
      end
      CMD_READ: res.hl = p_hl[it.index];
      default: ;
    endcase
    res.sel = last_sel;
    res.sx = last_x;
    res.sy = last_y;
    res.sz = last_z;
    return res;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_item_t nx;
    int g;
    if (!rst_ni) begin
      in_valid_i <= 0;
      cmd_i <= CMD_WRITE;
      index_i <= 0;
      is_circle_i <= 0;
      center_x_i <= 0;
      center_y_i <= 0;
      radius_i <= 0;
      mouse_x_i <= 0;
      mouse_y_i <= 0;
      mouse_z_i <= 0;
      in_gap <= 0;
    end else begin
      g = in_gap;
      if (in_valid_i && in_ready_o) begin
        nx.cmd = cmd_e'(cmd_i);
        nx.index = index_i;
        nx.is_circle = is_circle_i;
        nx.cx = center_x_i;
        nx.cy = center_y_i;
        nx.r = radius_i;
        nx.mx = mouse_x_i;
        nx.my = mouse_y_i;
        nx.mz = mouse_z_i;
        expected_results.push_back(predict_snap(nx));
        accepted++;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (!in_valid_i || in_ready_o) begin
        if (g == 0 && pend_cmds.size() != 0) begin
          nx = pend_cmds.pop_front();
          cmd_i <= nx.cmd;
          index_i <= nx.index;
          is_circle_i <= nx.is_circle;
          center_x_i <= nx.cx;
          center_y_i <= nx.cy;
          radius_i <= nx.r;
          mouse_x_i <= nx.mx;
          mouse_y_i <= nx.my;
          mouse_z_i <= nx.mz;
          in_valid_i <= 1;
        end else begin
          in_valid_i <= 0;
          if (g != 0) g--;
        end
      end
      in_gap <= g;
    end
  end

  // long receiver hold-off once, so the block stalls its input
  int hold_cnt;
  logic hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_done <= 0;
    end else if (!hold_done && accepted >= 60) begin
      hold_cnt <= 3000;
      hold_done <= 1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  int out_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    snap_result_t e;
    int s;
    if (!rst_ni) begin
      out_ready_i <= 0;
      out_stall <= 0;
    end else begin
      s = out_stall;
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (hit_o !== e.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.hit, hit_o);
            errors++;
          end
          if (selected_index_o !== e.sel) begin
            $display("%0t: selected_index exp %0d got %0d", $time, e.sel, selected_index_o);
            errors++;
          end
          if (snap_x_o !== e.sx) begin
            $display("%0t: snap_x exp %h got %h", $time, e.sx, snap_x_o);
            errors++;
          end
          if (snap_y_o !== e.sy) begin
            $display("%0t: snap_y exp %h got %h", $time, e.sy, snap_y_o);
            errors++;
          end
          if (snap_z_o !== e.sz) begin
            $display("%0t: snap_z exp %h got %h", $time, e.sz, snap_z_o);
            errors++;
          end
          if (highlight_o !== e.hl) begin
            $display("%0t: highlight exp %0d got %0d", $time, e.hl, highlight_o);
            errors++;
          end
        end
        s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else if (s != 0) begin
        s--;
      end
      out_ready_i <= (s == 0 && hold_cnt == 0);
      out_stall <= s;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v[31:0];
  endfunction

  task automatic push_write(int idx, logic circ, logic [31:0] cx, logic [31:0] cy,
                            logic [30:0] r);
    cmd_item_t it;
    it = '{CMD_WRITE, idx[7:0], circ, cx, cy, r, $urandom, $urandom, $urandom};
    g_cx[idx] = cx;
    g_cy[idx] = cy;
    g_r[idx] = r;
    pend_cmds.push_back(it);
  endtask

  task automatic push_cmd(cmd_e c, int idx, logic [31:0] mx, logic [31:0] my,
                          logic [31:0] mz);
    cmd_item_t it;
    it = '{c, idx[7:0], 1'($urandom), $urandom, $urandom, 31'($urandom), mx, my, mz};
    pend_cmds.push_back(it);
  endtask

  task automatic write_random(int idx);
    if ($urandom_range(0, 4) == 0)
      push_write(idx, 1'($urandom), $urandom, $urandom, 31'($urandom));
    else
      push_write(idx, $urandom_range(0, 5) != 0,
                 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)),
                 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)),
                 31'($urandom_range(0, 1 << 21)));
  endtask

  // pick aimed at the ring of a circle in the scanned range
  task automatic pick_near();
    int i;
    longint cx, cy, rr, j1, j2, sd;
    i = $urandom_range(0, (g_count > SLOTS ? SLOTS : g_count) - 1);
    cx = longint'(signed'(g_cx[i]));
    cy = longint'(signed'(g_cy[i]));
    rr = g_r[i];
    sd = g_snap > 31'h7FFFFF ? 64'h7FFFFF : longint'(g_snap);
    j1 = longint'($urandom_range(0, 32'(2 * sd))) - sd;
    j2 = longint'($urandom_range(0, 32'(sd))) - sd / 2;
    if ($urandom_range(0, 1)) rr = -rr;
    if ($urandom_range(0, 1))
      push_cmd(CMD_PICK, 0, clamp32(cx + rr + j1), clamp32(cy + j2), $urandom);
    else
      push_cmd(CMD_PICK, 0, clamp32(cx + j2), clamp32(cy + rr + j1), $urandom);
  endtask

  task automatic random_items(int n);
    int k;
    for (int m = 0; m < n; m++) begin
      k = $urandom_range(0, 99);
      if (k < 12) write_random($urandom_range(0, 255));
      else if (k < 70 && g_count > 0) pick_near();
      else if (k < 82) push_cmd(CMD_PICK, 0, $urandom, $urandom, $urandom);
      else if (k < 95) push_cmd(CMD_READ, $urandom_range(0, 255), $urandom, $urandom,
                                $urandom);
      else push_cmd(CMD_RSVD, $urandom_range(0, 255), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_idle();
    wait (pend_cmds.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    if (idx == REG_SNAP_DIST) begin
      p_snap = data[30:0];
      g_snap = data[30:0];
    end else begin
      ent_count = data[8:0];
      g_count = int'(data[8:0]);
    end
  endtask

  task automatic run_phase(logic [30:0] sd, logic [8:0] cnt, int n);
    wait_idle();
    cfg_write(REG_SNAP_DIST, {1'b0, sd});
    cfg_write(REG_ENT_COUNT, {23'd0, cnt});
    random_items(n);
  endtask

  initial begin
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_index_i = REG_SNAP_DIST;
    cfg_data_i = 0;
    p_snap = SNAP_RESET;
    ent_count = 0;
    g_snap = SNAP_RESET;
    g_count = 0;
    last_x = 0;
    last_y = 0;
    last_z = 0;
    last_sel = 0;
    for (int i = 0; i < SLOTS; i++) begin
      p_circle[i] = 0;
      p_cx[i] = 0;
      p_cy[i] = 0;
      p_r[i] = 0;
      p_hl[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // directed: pick with an empty scan, then a small table
    push_cmd(CMD_PICK, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    push_write(0, 1'b0, 0, 0, 31'h7FFFFFFF);
    push_write(1, 1'b1, 0, 0, 31'd655360);
    push_write(2, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
    push_write(3, 1'b1, 32'h80000000, 32'h80000000, 31'h7FFFFFFF);
    push_write(4, 1'b1, 32'h00100000, 0, 31'd0);
    push_write(5, 1'b1, 32'hFFF00000, 32'h00030000, 31'd131072);
    push_write(6, 1'b0, 32'h12345678, 32'h9ABCDEF0, 31'd65536);
    push_write(7, 1'b1, 32'h80000000, 32'h7FFFFFFF, 31'd1);
    push_write(255, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h55555555);
    wait_idle();
    cfg_write(REG_ENT_COUNT, 32'd8);
    push_cmd(CMD_PICK, 0, 0, 0, 32'h11);                          // coinciding centers
    push_cmd(CMD_PICK, 0, 32'd983040, 0, 32'h80000000);           // hit on the ring
    push_cmd(CMD_PICK, 0, 32'd655360, 32'd655360, 32'h22);
    push_cmd(CMD_PICK, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h33);     // far corner
    push_cmd(CMD_PICK, 0, 32'h00140000, 0, 32'h44);               // zero radius
    push_cmd(CMD_PICK, 0, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    push_cmd(CMD_READ, 1, 0, 0, 0);
    push_cmd(CMD_READ, 255, 0, 0, 0);
    push_cmd(CMD_READ, 0, 0, 0, 0);
    push_cmd(CMD_RSVD, 1, 0, 0, 0);
    push_write(1, 1'b1, 0, 0, 31'd65536);                         // rewrite keeps mark
    push_cmd(CMD_READ, 1, 0, 0, 0);
    push_cmd(CMD_PICK, 0, 32'h0DEAD000, 32'h0BEEF000, 32'h55);      // miss keeps snap

    // fill the rest of the table so every count is legal
    wait_idle();
    for (int i = 8; i < 255; i++) write_random(i);
    run_phase(31'd196608, 9'd8, 150);
    run_phase(31'd0, 9'd16, 150);
    run_phase(31'h7FFFFFFF, 9'd4, 150);
    run_phase(31'($urandom_range(1, 1 << 20)), 9'd32, 150);
    run_phase(31'($urandom_range(1 << 16, 1 << 22)), 9'd1, 150);
    run_phase(31'($urandom), 9'd256, 40);
    run_phase(31'($urandom_range(1, 1 << 21)), 9'd511, 30);
    run_phase(31'd327680, 9'd0, 30);
    run_phase(31'($urandom_range(1 << 15, 1 << 19)), 9'd12, 150);

    wait (pend_cmds.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
